@@ sv/tdma_frame_clock_sync_defines.svh @@
// Assertion macros shared by the TDMA frame clock RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TDMA_FRAME_CLOCK_SYNC_DEFINES_SVH
`define TDMA_FRAME_CLOCK_SYNC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TFCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tfcs_pkg.sv @@
// Package for the TDMA frame clock: constants, register indexes, sequencer states
// and the control/status structs between the sequencer and the divider.
// No dependencies.
package tfcs_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned CNT_W  = 7;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_PERIOD_RST = 24'd100000;
    localparam logic [CFG_W-1:0] SLOT_LENGTH_RST  = 24'd20000;
    localparam logic [CFG_W-1:0] GUARD_LENGTH_RST = 24'd2000;

    // Register indexes
    localparam logic [1:0] REG_FRAME_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLOT_LENGTH  = 2'd1;
    localparam logic [1:0] REG_GUARD_LENGTH = 2'd2;

    // Item kinds
    localparam logic KIND_BEACON = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [7:0] NO_SLOT = 8'hff;

    // Divider pass lengths in bits
    localparam logic [CNT_W-1:0] DIV_BITS_WIDE   = 7'd64;
    localparam logic [CNT_W-1:0] DIV_BITS_NARROW = 7'd24;

    // Sequencer states
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_LOCK = 11'b000_0000_0010,
        ST_EXP  = 11'b000_0000_0100,
        ST_ERR  = 11'b000_0000_1000,
        ST_DIV8 = 11'b000_0001_0000,
        ST_OFS  = 11'b000_0010_0000,
        ST_FS   = 11'b000_0100_0000,
        ST_CMP  = 11'b000_1000_0000,
        ST_D1   = 11'b001_0000_0000,
        ST_D2S  = 11'b010_0000_0000,
        ST_D2   = 11'b100_0000_0000
    } tfcs_state_t;

    typedef struct packed {
        logic start;
        logic wide;     // 1: 64-bit dividend, 0: dividend fits in 24 bits
    } tfcs_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, results valid from this cycle on
    } tfcs_div_stat_t;

endpackage

@@ sv/tfcs_divider.sv @@
// Shared restoring divider: 64-bit (or 24-bit) dividend by a 24-bit divisor,
// one quotient bit per cycle. Depends on tfcs_pkg.
module tfcs_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tfcs_pkg::tfcs_div_ctrl_t ctrl,
    input  logic [63:0]             dividend,
    input  logic [23:0]             divisor,
    output tfcs_pkg::tfcs_div_stat_t stat,
    output logic [63:0]             quotient,
    output logic [23:0]             remainder
);
    import tfcs_pkg::*;

    logic [63:0]      q_reg;
    logic [23:0]      rem_reg;
    logic [23:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [24:0] rem_shift;
    logic        ge;
    logic [24:0] rem_sub;

    // One restoring step
    assign rem_shift = {rem_reg, q_reg[63]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // Control: counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.wide ? DIV_BITS_WIDE : DIV_BITS_NARROW;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: narrow dividends are left-aligned so only 24 steps are needed
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            q_reg   <= ctrl.wide ? dividend : {dividend[23:0], 40'd0};
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= ge ? rem_sub[23:0] : rem_shift[23:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/tdma_frame_clock_sync.sv @@
// TDMA frame clock top level. A locked query uses the shared divider: 64 steps of frame
// reduction, 24 of slot division; a query while unlocked or before the frame start skips
// it. A beacon passes LOCK if unlocked, else EXP, ERR, DIV8, OFS, FS. Zero frame period:
// one 64-step pass; zero slot length: no slot pass. The next transaction is accepted
// once the result is in the output register. Async active-low reset: unlocked, clock
// zeroed, registers at defaults. Depends on tfcs_pkg, tfcs_divider, the defines file.
`include "tdma_frame_clock_sync_defines.svh"

module tdma_frame_clock_sync (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] beacon_frame,
    input  logic signed [63:0] time_us,
    input  logic [7:0]  query_slot,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  current_slot,
    output logic        in_guard,
    output logic signed [63:0] slot_start,
    output logic        is_locked,
    output logic [15:0] frame_number
);
    import tfcs_pkg::*;

    tfcs_state_t state_reg, state_next;

    logic [23:0] frame_period_reg;
    logic [23:0] slot_length_reg;
    logic [23:0] guard_length_reg;

    logic [63:0] frame_start_reg;
    logic [63:0] sync_offset_reg;
    logic [15:0] stored_frame_reg;
    logic        locked_reg;

    logic        kind_reg;
    logic [15:0] bframe_reg;
    logic [63:0] time_reg;
    logic [7:0]  qslot_reg;

    logic [63:0] tmp_reg;
    logic [31:0] prod_reg;
    logic [63:0] elapsed_reg;
    logic [7:0]  cur_reg;
    logic        guard_reg;
    logic        fin_reg;

    logic        out_valid_reg;
    logic [7:0]  out_slot_reg;
    logic        out_guard_reg;
    logic [63:0] out_start_reg;
    logic        out_locked_reg;
    logic [15:0] out_frame_reg;

    tfcs_div_ctrl_t div_ctrl;
    tfcs_div_stat_t div_stat;
    logic [63:0]    div_dividend;
    logic [23:0]    div_divisor;
    logic [63:0]    div_quot;
    logic [23:0]    div_rem;

    logic        in_acc;
    logic        out_free;
    logic        before_start;
    logic [63:0] diff;
    logic [63:0] err_bias;
    logic        guard_calc;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || fin_reg;

    assign before_start = $signed(time_reg) < $signed(frame_start_reg);
    assign diff         = time_reg - frame_start_reg;
    assign err_bias     = tmp_reg + {61'd0, {3{tmp_reg[63]}}};
    assign guard_calc   = (guard_length_reg >= slot_length_reg) ||
                          (div_rem >= (slot_length_reg - guard_length_reg));

    // Divider requests
    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_ctrl.wide  = 1'b1;
        div_dividend   = diff;
        div_divisor    = frame_period_reg;
        if (state_reg == ST_CMP)
        begin
            div_ctrl.start = locked_reg && !before_start && (frame_period_reg != 24'd0);
        end
        else if (state_reg == ST_D2S)
        begin
            div_ctrl.start = slot_length_reg != 24'd0;
            div_ctrl.wide  = frame_period_reg == 24'd0;
            div_dividend   = elapsed_reg;
            div_divisor    = slot_length_reg;
        end
    end

    tfcs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind == KIND_QUERY)
                        state_next = ST_CMP;
                    else if (locked_reg)
                        state_next = ST_EXP;
                    else
                        state_next = ST_LOCK;
                end
            end
            ST_LOCK: state_next = ST_CMP;
            ST_EXP:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_DIV8;
            ST_DIV8: state_next = ST_OFS;
            ST_OFS:  state_next = ST_FS;
            ST_FS:   state_next = ST_CMP;
            ST_CMP:
            begin
                if (!locked_reg || before_start)
                    state_next = ST_IDLE;
                else if (frame_period_reg == 24'd0)
                    state_next = ST_D2S;
                else
                    state_next = ST_D1;
            end
            ST_D1:
            begin
                if (div_stat.done)
                    state_next = ST_D2S;
            end
            ST_D2S:
            begin
                if (slot_length_reg == 24'd0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_D2;
            end
            ST_D2:
            begin
                if (div_stat.done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg <= FRAME_PERIOD_RST;
            slot_length_reg  <= SLOT_LENGTH_RST;
            guard_length_reg <= GUARD_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                REG_SLOT_LENGTH:  slot_length_reg  <= cfg_data;
                REG_GUARD_LENGTH: guard_length_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_start_reg  <= '0;
            sync_offset_reg  <= '0;
            stored_frame_reg <= '0;
            locked_reg       <= 1'b0;
            fin_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_reg && out_free)
                fin_reg <= 1'b0;
            unique case (state_reg)
                ST_LOCK:
                begin
                    frame_start_reg  <= time_reg;
                    sync_offset_reg  <= '0;
                    stored_frame_reg <= bframe_reg;
                    locked_reg       <= 1'b1;
                end
                ST_OFS:  sync_offset_reg <= sync_offset_reg + tmp_reg;
                ST_FS:
                begin
                    frame_start_reg  <= time_reg - sync_offset_reg;
                    stored_frame_reg <= bframe_reg;
                end
                ST_CMP:
                begin
                    if (!locked_reg || before_start)
                        fin_reg <= 1'b1;
                end
                ST_D2S:
                begin
                    if (slot_length_reg == 24'd0)
                        fin_reg <= 1'b1;
                end
                ST_D2:
                begin
                    if (div_stat.done)
                        fin_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Item and scratch datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg   <= kind;
            bframe_reg <= beacon_frame;
            time_reg   <= time_us;
            qslot_reg  <= query_slot;
        end
        unique case (state_reg)
            ST_EXP:  tmp_reg <= frame_start_reg + {40'd0, frame_period_reg};
            ST_ERR:  tmp_reg <= time_reg - tmp_reg;
            // truncating divide by eight: bias negatives by seven, then shift
            ST_DIV8: tmp_reg <= {{3{err_bias[63]}}, err_bias[63:3]};
            ST_CMP:
            begin
                prod_reg    <= {24'd0, qslot_reg} * {8'd0, slot_length_reg};
                elapsed_reg <= diff;
                cur_reg     <= NO_SLOT;
                guard_reg   <= 1'b1;
            end
            ST_D1:
            begin
                if (div_stat.done)
                    elapsed_reg <= {40'd0, div_rem};
            end
            ST_D2:
            begin
                if (div_stat.done)
                begin
                    cur_reg   <= div_quot[7:0];
                    guard_reg <= guard_calc;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_reg && out_free)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_reg && out_free)
        begin
            out_slot_reg   <= cur_reg;
            out_guard_reg  <= guard_reg;
            out_start_reg  <= frame_start_reg + {32'd0, prod_reg};
            out_locked_reg <= locked_reg;
            out_frame_reg  <= stored_frame_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_slot = out_slot_reg;
    assign in_guard     = out_guard_reg;
    assign slot_start   = out_start_reg;
    assign is_locked    = out_locked_reg;
    assign frame_number = out_frame_reg;

    // Checks
    `TFCS_ASSERT_NOW(a_idle_div_quiet, clk, rst_n, !in_stall, !div_stat.busy,
        "divider busy while accepting")
    `TFCS_ASSERT_NEXT(a_lock_sticky, clk, rst_n, locked_reg, locked_reg,
        "lock dropped")
    `TFCS_ASSERT_NOW(a_done_expected, clk, rst_n, div_stat.done,
        (state_reg == ST_D1) || (state_reg == ST_D2), "unexpected divider done")
    `TFCS_ASSERT_NOW(a_unlocked_result, clk, rst_n, out_valid_reg && !out_locked_reg,
        out_guard_reg && (out_slot_reg == NO_SLOT), "unlocked result not flagged")
    `TFCS_ASSERT_NEXT(a_beacon_path, clk, rst_n,
        (state_reg == ST_EXP) && (kind_reg == KIND_BEACON), state_reg == ST_ERR,
        "beacon sequence broken")

endmodule

@@ sim/frame_clock_checker.sv @@
`timescale 1ns / 100ps
// Passive checker for the TDMA frame clock: follows the register port and both
// channels, predicts each result and compares it. Depends on tfcs_pkg.
module frame_clock_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic [15:0]        beacon_frame,
    input  logic signed [63:0] time_us,
    input  logic [7:0]         query_slot,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         current_slot,
    input  logic               in_guard,
    input  logic signed [63:0] slot_start,
    input  logic               is_locked,
    input  logic [15:0]        frame_number,
    output int                 mismatch_count,
    output int                 pending_results,
    output int                 results_seen
);
    import tfcs_pkg::*;

    localparam int SYNC_SHIFT = 3;

    typedef struct packed {
        logic [7:0]  slot;
        logic        guard;
        logic [63:0] start;
        logic        locked;
        logic [15:0] frame;
    } slot_timing_t;

    slot_timing_t timing_queue[$];

    // Register copies, zero-extended to the time width
    logic [63:0] period_q;
    logic [63:0] slot_len_q;
    logic [63:0] guard_len_q;

    // Clock state
    logic [63:0] frame_start_q;
    logic [63:0] sync_offset_q;
    logic [15:0] frame_q;
    logic        locked_q;

    // Apply one transaction to the clock state and return the timing it reports
    function automatic slot_timing_t advance_frame_clock(
        input logic        k,
        input logic [15:0] bf,
        input logic [63:0] t,
        input logic [7:0]  qs
    );
        logic [63:0] err;
        logic [63:0] mag;
        logic [63:0] step;
        logic [63:0] elapsed;
        logic [63:0] quo;
        logic [63:0] pos;
        slot_timing_t res;

        // Beacon: lock on first arrival, else steer by an eighth of the error
        if (k == KIND_BEACON) begin
            if (!locked_q) begin
                frame_start_q = t;
                sync_offset_q = '0;
                locked_q      = 1'b1;
            end
            else begin
                err  = t - (frame_start_q + period_q);
                mag  = err[63] ? -err : err;
                step = mag >> SYNC_SHIFT;
                sync_offset_q = sync_offset_q + (err[63] ? -step : step);
                frame_start_q = t - sync_offset_q;
            end
            frame_q = bf;
        end

        // Slot position; divide by zero gives all-ones quotient, dividend remainder
        res.slot  = NO_SLOT;
        res.guard = 1'b1;
        if (locked_q && !($signed(t) < $signed(frame_start_q))) begin
            elapsed = t - frame_start_q;
            if (period_q != 0)
                elapsed = elapsed % period_q;
            if (slot_len_q == 0) begin
                quo = '1;
                pos = elapsed;
            end
            else begin
                quo = elapsed / slot_len_q;
                pos = elapsed % slot_len_q;
            end
            res.slot  = quo[7:0];
            res.guard = (guard_len_q >= slot_len_q) || (pos >= slot_len_q - guard_len_q);
        end

        res.start  = frame_start_q + {56'b0, qs} * slot_len_q;
        res.locked = locked_q;
        res.frame  = frame_q;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, actual 0x%h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Track register writes, check results, queue predictions
    always @(posedge clk or negedge rst_n) begin : track
        slot_timing_t want;
        if (!rst_n) begin
            period_q      = {40'b0, FRAME_PERIOD_RST};
            slot_len_q    = {40'b0, SLOT_LENGTH_RST};
            guard_len_q   = {40'b0, GUARD_LENGTH_RST};
            frame_start_q = '0;
            sync_offset_q = '0;
            frame_q       = '0;
            locked_q      = 1'b0;
            timing_queue.delete();
            pending_results = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_PERIOD: period_q    = {40'b0, cfg_data};
                    REG_SLOT_LENGTH:  slot_len_q  = {40'b0, cfg_data};
                    REG_GUARD_LENGTH: guard_len_q = {40'b0, cfg_data};
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (out_valid && !out_stall) begin
                results_seen++;
                if (timing_queue.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    mismatch_count++;
                end
                else begin
                    want = timing_queue.pop_front();
                    check_field("current_slot", 64'(want.slot), 64'(current_slot));
                    check_field("in_guard", 64'(want.guard), 64'(in_guard));
                    check_field("slot_start", want.start, slot_start);
                    check_field("is_locked", 64'(want.locked), 64'(is_locked));
                    check_field("frame_number", 64'(want.frame), 64'(frame_number));
                end
            end

            if (in_valid && !in_stall)
                timing_queue.push_back(advance_frame_clock(kind, beacon_frame, time_us,
                                                           query_slot));
            pending_results = timing_queue.size();
        end
    end

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
        results_seen    = 0;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the TDMA frame clock testbench: clock, reset, register settings,
// beacon/query stimulus with random idling, verdict. Depends on tfcs_pkg,
// tdma_frame_clock_sync and frame_clock_checker.
module tb_top;
    import tfcs_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int PHASE_ITEMS     = 75;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT  = 5000;

    // index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic signed [63:0] TIME_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [1:0]         cfg_index    = REG_FRAME_PERIOD;
    logic [23:0]        cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               kind         = KIND_QUERY;
    logic [15:0]        beacon_frame = '0;
    logic signed [63:0] time_us      = '0;
    logic [7:0]         query_slot   = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [7:0]         current_slot;
    logic               in_guard;
    logic signed [63:0] slot_start;
    logic               is_locked;
    logic [15:0]        frame_number;

    int mismatch_count;
    int pending_results;
    int results_seen;

    // stimulus bookkeeping
    logic [23:0]        cur_period    = FRAME_PERIOD_RST;
    logic signed [63:0] anchor        = '0;
    logic [15:0]        frame_seq     = '0;
    bit                 burst_mode    = 1'b0;
    int                 hold_requests = 0;
    int                 beacons_sent  = 0;
    int                 queries_sent  = 0;
    int                 phases_run    = 1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    tdma_frame_clock_sync DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .beacon_frame (beacon_frame),
        .time_us      (time_us),
        .query_slot   (query_slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .current_slot (current_slot),
        .in_guard     (in_guard),
        .slot_start   (slot_start),
        .is_locked    (is_locked),
        .frame_number (frame_number)
    );

    frame_clock_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .beacon_frame    (beacon_frame),
        .time_us         (time_us),
        .query_slot      (query_slot),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .current_slot    (current_slot),
        .in_guard        (in_guard),
        .slot_start      (slot_start),
        .is_locked       (is_locked),
        .frame_number    (frame_number),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction, hold it until taken, then maybe idle
    task automatic send_item(
        input logic               k,
        input logic [15:0]        bf,
        input logic signed [63:0] t,
        input logic [7:0]         qs
    );
        int gap;
        in_valid     <= 1'b1;
        kind         <= k;
        beacon_frame <= bf;
        time_us      <= t;
        query_slot   <= qs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (k == KIND_BEACON) begin
            beacons_sent++;
            anchor    = t;
            frame_seq = bf;
        end
        else
            queries_sent++;
        @(negedge clk);
        gap = burst_mode ? 0 : idle_cycles();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Mostly beacons on the frame grid and queries around it; some raw noise
    task automatic send_random_item();
        longint             span;
        longint             jit;
        longint             off;
        logic               k;
        logic [15:0]        bf;
        logic signed [63:0] t;
        logic [7:0]         qs;
        span = (cur_period == 0) ? 1000 : cur_period;
        qs   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 3) == 0) begin
                k   = KIND_BEACON;
                jit = longint'($urandom_range(0, span / 8)) - span / 16;
                t   = anchor + span + jit;
                bf  = ($urandom_range(0, 9) != 0) ? frame_seq + 16'd1 : 16'($urandom);
            end
            else begin
                k   = KIND_QUERY;
                off = longint'($urandom_range(0, 2 * span + span / 4)) - span / 4;
                t   = anchor + off;
                bf  = 16'($urandom);
            end
        end
        else begin
            k  = ($urandom_range(0, 99) < 15) ? KIND_BEACON : KIND_QUERY;
            bf = 16'($urandom);
            t  = {$urandom, $urandom};
            qs = 8'($urandom);
        end
        send_item(k, bf, t, qs);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // Write all registers and the spare index on consecutive cycles, block idle
    task automatic write_settings(input logic [23:0] p, input logic [23:0] s,
                                  input logic [23:0] g);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_PERIOD;
        cfg_data  <= p;
        @(negedge clk);
        cfg_index <= REG_SLOT_LENGTH;
        cfg_data  <= s;
        @(negedge clk);
        cfg_index <= REG_GUARD_LENGTH;
        cfg_data  <= g;
        @(negedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 24'($urandom);
        @(negedge clk);
        cfg_we     <= 1'b0;
        cur_period  = p;
    endtask

    // One register setting followed by random traffic
    task automatic run_phase(input logic [23:0] p, input logic [23:0] s,
                             input logic [23:0] g, input bit hold);
        wait_drained();
        write_settings(p, s, g);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            // receiver holds off while the sender keeps offering back to back
            if (hold && i == 20) begin
                hold_requests++;
                burst_mode = 1'b1;
            end
            if (hold && i == 32)
                burst_mode = 1'b0;
            if (i == PHASE_ITEMS / 2)
                wait_drained();
            send_random_item();
        end
        phases_run++;
    endtask

    // Receiver stall pattern, with long hold-offs on request
    initial begin : receiver
        int  hold_served;
        int  run;
        bit  stall_now;
        hold_served = 0;
        forever begin
            if (hold_requests != hold_served) begin
                hold_served++;
                stall_now = 1'b1;
                run       = HOLD_OFF_CYCLES;
            end
            else if (!out_stall) begin
                run       = idle_cycles();
                stall_now = (run != 0);
                if (!stall_now)
                    run = $urandom_range(1, 8);
            end
            else begin
                stall_now = 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
            end
            out_stall <= stall_now;
            repeat (run) @(negedge clk);
        end
    end

    // Ends the run when no transaction moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Unlocked: no slot, slot start from a zero frame start
        send_item(KIND_QUERY, 16'h0000, 64'sd0, 8'd0);
        send_item(KIND_QUERY, 16'hffff, TIME_MAX, 8'd255);
        send_item(KIND_QUERY, 16'h0000, TIME_MIN, 8'd1);

        // First beacon locks at its receive time
        send_item(KIND_BEACON, 16'h0001, 64'sd1000, 8'd3);

        // Before the frame start, slot edges, guard band, frame wrap
        send_item(KIND_QUERY, 16'h0000, 64'sd999, 8'd0);
        send_item(KIND_QUERY, 16'h0000, 64'sd1000, 8'd0);
        send_item(KIND_QUERY, 16'h0000, 64'sd18999, 8'd4);
        send_item(KIND_QUERY, 16'h0000, 64'sd19000, 8'd5);
        send_item(KIND_QUERY, 16'h0000, 64'sd100999, 8'd255);
        send_item(KIND_QUERY, 16'h0000, 64'sd101000, 8'd0);

        // Late and early beacons: positive and negative error truncation
        send_item(KIND_BEACON, 16'h0002, 64'sd101040, 8'd0);
        send_item(KIND_BEACON, 16'hffff, 64'sd200935, 8'd2);

        // Wrapping sums near both ends of the time range
        send_item(KIND_BEACON, 16'h0000, TIME_MAX - 64'sd15, 8'd255);
        send_item(KIND_QUERY, 16'h1234, TIME_MIN, 8'd0);
        send_item(KIND_QUERY, 16'h0000, TIME_MAX, 8'd255);
        send_item(KIND_BEACON, 16'h8000, TIME_MIN + 64'sd5, 8'd7);
        send_item(KIND_QUERY, 16'h0000, TIME_MAX, 8'd0);
        send_item(KIND_QUERY, 16'hffff, TIME_MIN, 8'd255);

        // Register settings: defaults, extremes, zero divisors, wide guard
        run_phase(24'd100000, 24'd20000, 24'd2000, 1'b1);
        run_phase(24'hffffff, 24'hffffff, 24'h000000, 1'b0);
        run_phase(24'd1, 24'd1, 24'd0, 1'b0);
        run_phase(24'd1000000, 24'd1, 24'd0, 1'b1);
        run_phase(24'd0, 24'd0, 24'd5, 1'b0);
        run_phase(24'd50000, 24'd7000, 24'd9000, 1'b0);
        begin : random_setting
            logic [23:0] p;
            logic [23:0] s;
            p = 24'($urandom_range(1000, 200000));
            s = p / 24'($urandom_range(1, 12));
            run_phase(p, s, 24'($urandom_range(0, s - 1)), 1'b0);
        end
        run_phase(24'hffffff, 24'd1000, 24'hffffff, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d beacons and %0d queries over %0d register settings.",
                 beacons_sent, queries_sent, phases_run);
        $display("Compared %0d results, %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
